@@ hw/rtl/ohlc_pkg.sv @@
// ----------------------------------------------------------------------------
// OHLC aggregator package
// Shared widths, register indexes, reset values and state encoding.
// ----------------------------------------------------------------------------
package ohlc_pkg;

    localparam int TS_W       = 40;
    localparam int CFG_W      = 17;
    localparam int TIME_W     = 50;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_W-1:0] BUCKET_SECONDS_RST = 17'd14400;
    localparam logic [CFG_W-1:0] CLOSE_OFFSET_RST   = 17'd14399;
    localparam logic [CFG_W-1:0] MS_PER_SECOND      = 17'd1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BUCKET_SECONDS = 1'b0,
        CFG_CLOSE_OFFSET   = 1'b1
    } t_cfg_addr;

    typedef enum logic {
        KIND_BAR = 1'b0,
        KIND_EOS = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_CMP,
        S_TR_BASE,
        S_TR_HIGH,
        S_TR_LOW,
        S_SUM_OLD,
        S_SUM_NEW,
        S_MUL_BS,
        S_MUL_OFF,
        S_MUL_K,
        S_ATR_GO,
        S_ATR_WAIT,
        S_OUT
    } t_state;

endpackage

@@ hw/rtl/ohlc_bar_if.sv @@
// ----------------------------------------------------------------------------
// OHLC bar channel
// Valid/ready channel carrying one price bar or an end-of-stream marker.
// ----------------------------------------------------------------------------
interface ohlc_bar_if
    import ohlc_pkg::*;
#(
    parameter int PRICE_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [TS_W-1:0]       bar_seconds;
    logic [PRICE_BITS-1:0] bar_open;
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic [PRICE_BITS-1:0] bar_close;

    modport source (
        output valid, kind, bar_seconds, bar_open, bar_high, bar_low, bar_close,
        input  ready
    );

    modport sink (
        input  valid, kind, bar_seconds, bar_open, bar_high, bar_low, bar_close,
        output ready
    );
endinterface

@@ hw/rtl/ohlc_res_if.sv @@
// ----------------------------------------------------------------------------
// OHLC result channel
// Valid/ready channel carrying one finished bucket with its ATR.
// ----------------------------------------------------------------------------
interface ohlc_res_if
    import ohlc_pkg::*;
#(
    parameter int PRICE_BITS = 32
) ();
    logic                    valid;
    logic                    ready;
    logic [TIME_W-1:0]       close_time_ms;
    logic [PRICE_BITS-1:0]   out_open;
    logic [PRICE_BITS-1:0]   out_high;
    logic [PRICE_BITS-1:0]   out_low;
    logic [PRICE_BITS-1:0]   out_close;
    logic [PRICE_BITS+3:0]   atr_x16;
    logic                    atr_valid;

    modport source (
        output valid, close_time_ms, out_open, out_high, out_low, out_close,
               atr_x16, atr_valid,
        input  ready
    );

    modport sink (
        input  valid, close_time_ms, out_open, out_high, out_low, out_close,
               atr_x16, atr_valid,
        output ready
    );
endinterface

@@ hw/rtl/ohlc_serial_div.sv @@
// ----------------------------------------------------------------------------
// OHLC serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ohlc_serial_div #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dsor;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  rem_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
        rem_diff = rem_sh - {1'b0, r_dsor};
        rem_ge   = (rem_sh >= {1'b0, r_dsor});
        n_rem    = rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], rem_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hw/rtl/ohlc_bucket_aggregator_atr.sv @@
// ----------------------------------------------------------------------------
// OHLC bucket aggregator with ATR
// Groups price bars into time buckets and emits each finished bucket with
// its close time in milliseconds and a simple-mean average true range.
// ----------------------------------------------------------------------------
// A bar that stays in its bucket passes through the 40-step serial divider
// (at default parameters) and a compare; a bar that closes a bucket, and end
// of stream with a bucket open, also run true range, window sum, close time
// and ATR. One transaction is worked on at a time; the divider (bucket
// number, then ATR) and the one-bit-per-cycle time multiplier are serial.
// Synchronous reset clears bucket and ATR state and loads 14400 / 14399 into
// the registers; the range window memory is not cleared.
// ----------------------------------------------------------------------------
module ohlc_bucket_aggregator_atr
    import ohlc_pkg::*;
#(
    parameter int ATR_PERIOD = 14,
    parameter int PRICE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    ohlc_bar_if.sink              i_bar,
    ohlc_res_if.source            o_res
);

    localparam int SUM_W  = PRICE_BITS + $clog2(ATR_PERIOD);
    localparam int ATR_W  = PRICE_BITS + 4;
    localparam int DIV_W  = (SUM_W + 4 > TS_W) ? SUM_W + 4 : TS_W;
    localparam int WIDX_W = $clog2(ATR_PERIOD);
    localparam int FILL_W = $clog2(ATR_PERIOD + 1);

    // configuration
    logic [CFG_W-1:0]      r_bucket_seconds;
    logic [CFG_W-1:0]      r_close_offset;

    // control and bucket state
    t_state                r_state;
    t_state                n_state;
    logic                  r_flush;
    logic                  r_open;
    logic [TS_W-1:0]       r_bnum;
    logic [PRICE_BITS-1:0] r_open_px;
    logic [PRICE_BITS-1:0] r_high;
    logic [PRICE_BITS-1:0] r_low;
    logic [PRICE_BITS-1:0] r_close;
    logic [PRICE_BITS-1:0] r_prev_close;
    logic                  r_prev_seen;
    logic [WIDX_W-1:0]     r_widx;
    logic [FILL_W-1:0]     r_fill;
    logic [SUM_W-1:0]      r_sum;

    // range window
    logic [PRICE_BITS-1:0] r_win [ATR_PERIOD];
    logic [PRICE_BITS-1:0] r_win_rd;

    // working registers
    logic [PRICE_BITS-1:0] r_in_open;
    logic [PRICE_BITS-1:0] r_in_high;
    logic [PRICE_BITS-1:0] r_in_low;
    logic [PRICE_BITS-1:0] r_in_close;
    logic [TS_W-1:0]       r_qts;
    logic [PRICE_BITS-1:0] r_tr;
    logic [TIME_W-1:0]     r_acc;
    logic [TIME_W-1:0]     r_mcand;
    logic [CFG_W-1:0]      r_mplier;

    // output register
    logic                  r_ovalid;
    logic [TIME_W-1:0]     r_o_time;
    logic [PRICE_BITS-1:0] r_o_open;
    logic [PRICE_BITS-1:0] r_o_high;
    logic [PRICE_BITS-1:0] r_o_low;
    logic [PRICE_BITS-1:0] r_o_close;
    logic [ATR_W-1:0]      r_o_atr;
    logic                  r_o_atr_valid;

    // combinational
    logic                  bar_ready;
    logic                  bar_acc;
    logic                  out_free;
    logic                  full;
    logic [CFG_W-1:0]      bs_eff;
    logic [PRICE_BITS-1:0] tr_base;
    logic [PRICE_BITS-1:0] tr_op;
    logic [PRICE_BITS-1:0] tr_diff;
    logic [TIME_W-1:0]     mul_add;
    logic                  mul_last;
    logic                  st_load;
    logic                  st_clear;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [CFG_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;

    ohlc_serial_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CFG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        bar_acc  = i_bar.valid && bar_ready;
        out_free = !r_ovalid || o_res.ready;
        full     = (r_fill == FILL_W'(ATR_PERIOD));
        bs_eff   = (r_bucket_seconds == '0) ? CFG_W'(1) : r_bucket_seconds;
        tr_base  = (r_high >= r_low) ? r_high - r_low : '0;
        tr_op    = (r_state == S_TR_HIGH) ? r_high : r_low;
        tr_diff  = (tr_op >= r_prev_close) ? tr_op - r_prev_close : r_prev_close - tr_op;
        mul_add  = r_mplier[0] ? r_acc + r_mcand : r_acc;
        mul_last = (r_mplier[CFG_W-1:1] == '0);
        st_load  = ((r_state == S_CMP) && !r_open)
                || ((r_state == S_OUT) && out_free && !r_flush);
        st_clear = ((r_state == S_IDLE) && bar_acc && (i_bar.kind == KIND_EOS) && !r_open)
                || ((r_state == S_OUT) && out_free && r_flush);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (bar_acc) begin
                    if (i_bar.kind == KIND_BAR) begin
                        n_state = S_DIV;
                    end else if (r_open) begin
                        n_state = S_TR_BASE;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_open && (r_qts != r_bnum)) begin
                    n_state = S_TR_BASE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TR_BASE: n_state = r_prev_seen ? S_TR_HIGH : S_SUM_OLD;
            S_TR_HIGH: n_state = S_TR_LOW;
            S_TR_LOW:  n_state = S_SUM_OLD;
            S_SUM_OLD: n_state = S_SUM_NEW;
            S_SUM_NEW: n_state = S_MUL_BS;
            S_MUL_BS: begin
                if (mul_last) begin
                    n_state = S_MUL_OFF;
                end
            end
            S_MUL_OFF: n_state = S_MUL_K;
            S_MUL_K: begin
                if (mul_last) begin
                    n_state = S_ATR_GO;
                end
            end
            S_ATR_GO: n_state = full ? S_ATR_WAIT : S_OUT;
            S_ATR_WAIT: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        bar_ready    = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(i_bar.bar_seconds);
        div_divisor  = bs_eff;
        unique case (r_state)
            S_IDLE: begin
                bar_ready = 1'b1;
                div_start = i_bar.valid && (i_bar.kind == KIND_BAR);
            end
            S_ATR_GO: begin
                div_start    = full;
                div_dividend = DIV_W'({r_sum, 4'b0000});
                div_divisor  = CFG_W'(ATR_PERIOD);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_seconds <= BUCKET_SECONDS_RST;
            r_close_offset   <= CLOSE_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_BUCKET_SECONDS: r_bucket_seconds <= i_cfg_wdata;
                CFG_CLOSE_OFFSET:   r_close_offset   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_flush      <= 1'b0;
            r_open       <= 1'b0;
            r_bnum       <= '0;
            r_open_px    <= '0;
            r_high       <= '0;
            r_low        <= '0;
            r_close      <= '0;
            r_prev_close <= '0;
            r_prev_seen  <= 1'b0;
            r_widx       <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state) inside
                S_IDLE: begin
                    if (bar_acc) begin
                        r_flush <= (i_bar.kind == KIND_EOS);
                    end
                end
                S_CMP: begin
                    if (r_open && (r_qts == r_bnum)) begin
                        if (r_in_high > r_high) begin
                            r_high <= r_in_high;
                        end
                        if (r_in_low < r_low) begin
                            r_low <= r_in_low;
                        end
                        r_close <= r_in_close;
                    end
                end
                S_SUM_OLD: begin
                    if (full) begin
                        r_sum <= r_sum - SUM_W'(r_win_rd);
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                S_SUM_NEW: begin
                    r_sum        <= r_sum + SUM_W'(r_tr);
                    r_widx       <= (r_widx == WIDX_W'(ATR_PERIOD - 1)) ? '0 : r_widx + 1'b1;
                    r_prev_close <= r_close;
                    r_prev_seen  <= 1'b1;
                end
                default: begin
                end
            endcase

            if (st_load) begin
                r_open    <= 1'b1;
                r_bnum    <= r_qts;
                r_open_px <= r_in_open;
                r_high    <= r_in_high;
                r_low     <= r_in_low;
                r_close   <= r_in_close;
            end
            if (st_clear) begin
                r_open       <= 1'b0;
                r_bnum       <= '0;
                r_open_px    <= '0;
                r_high       <= '0;
                r_low        <= '0;
                r_close      <= '0;
                r_prev_close <= '0;
                r_prev_seen  <= 1'b0;
                r_widx       <= '0;
                r_fill       <= '0;
                r_sum        <= '0;
            end

            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bar_acc) begin
            r_in_open  <= i_bar.bar_open;
            r_in_high  <= i_bar.bar_high;
            r_in_low   <= i_bar.bar_low;
            r_in_close <= i_bar.bar_close;
        end
        unique case (r_state) inside
            S_DIV: begin
                if (div_done) begin
                    r_qts <= div_quo[TS_W-1:0];
                end
            end
            S_TR_BASE: r_tr <= tr_base;
            S_TR_HIGH, S_TR_LOW: begin
                if (tr_diff > r_tr) begin
                    r_tr <= tr_diff;
                end
            end
            S_SUM_NEW: begin
                r_acc    <= '0;
                r_mcand  <= TIME_W'(r_bnum);
                r_mplier <= bs_eff;
            end
            S_MUL_BS, S_MUL_K: begin
                r_acc    <= mul_add;
                r_mcand  <= {r_mcand[TIME_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[CFG_W-1:1]};
            end
            S_MUL_OFF: begin
                r_acc    <= '0;
                r_mcand  <= r_acc + TIME_W'(r_close_offset);
                r_mplier <= MS_PER_SECOND;
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_time      <= r_acc;
                    r_o_open      <= r_open_px;
                    r_o_high      <= r_high;
                    r_o_low       <= r_low;
                    r_o_close     <= r_close;
                    r_o_atr       <= full ? div_quo[ATR_W-1:0] : '0;
                    r_o_atr_valid <= full;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM_NEW) begin
            r_win[r_widx] <= r_tr;
        end
        r_win_rd <= r_win[r_widx];
    end

    assign i_bar.ready         = bar_ready;
    assign o_res.valid         = r_ovalid;
    assign o_res.close_time_ms = r_o_time;
    assign o_res.out_open      = r_o_open;
    assign o_res.out_high      = r_o_high;
    assign o_res.out_low       = r_o_low;
    assign o_res.out_close     = r_o_close;
    assign o_res.atr_x16       = r_o_atr;
    assign o_res.atr_valid     = r_o_atr_valid;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(ATR_PERIOD))
        else $error("window fill count beyond period");

    a_widx_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && (r_state != S_SUM_NEW)) |-> (r_widx == r_fill[WIDX_W-1:0]))
        else $error("window index out of step with fill count");

    a_atr_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_atr_valid) |-> (r_o_atr == '0))
        else $error("nonzero ATR without a full window");

    a_out_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !out_free) |=> (r_state == S_OUT))
        else $error("result dropped while output register busy");

endmodule
